// File: rtl/hex_memory_image_parser_macros.svh
// Assertion macros for the hex memory image parser.
// Each macro expands to one labelled concurrent assertion on the rising
// clock edge, disabled while reset is high.
`ifndef HEX_MEMORY_IMAGE_PARSER_MACROS_SVH
`define HEX_MEMORY_IMAGE_PARSER_MACROS_SVH

// Same-cycle implication
`define HMIP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define HMIP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/hmip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmip_pkg
// Shared types and constants of the hex memory image parser: result kinds,
// character codes, parser modes and the queue entry between front and back.
// ----------------------------------------------------------------------------
package hmip_pkg;

   // Result kinds
   localparam logic [1:0] KIND_BYTE    = 2'd0;
   localparam logic [1:0] KIND_SECTION = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;
   localparam logic [1:0] KIND_DONE    = 2'd3;

   // Characters of interest
   localparam logic [7:0] CHAR_AT    = 8'h40;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_VT    = 8'h0B;
   localparam logic [7:0] CHAR_FF    = 8'h0C;
   localparam logic [7:0] CHAR_CR    = 8'h0D;

   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   // Parser modes
   typedef enum logic [7:0] {
      MODE_IDLE    = 8'b0000_0001,
      MODE_SLASH   = 8'b0000_0010,
      MODE_LINE    = 8'b0000_0100,
      MODE_BLOCK   = 8'b0000_1000,
      MODE_STAR    = 8'b0001_0000,
      MODE_ADDR    = 8'b0010_0000,
      MODE_NIBBLE  = 8'b0100_0000,
      MODE_DISCARD = 8'b1000_0000
   } mode_type;

   // Work for the back end caused by one character
   typedef struct packed {
      logic        has_prim;   // byte or section start
      logic [1:0]  prim_kind;
      logic [31:0] addr;
      logic [7:0]  data;
      logic        has_term;   // run ends on this character
      logic        term_err;   // 1: error, 0: done
   } entry_type;

endpackage

// File: rtl/hmip_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmip_front
// Character classifier and parse state. Takes one character a cycle while the
// queue is not full, and pushes one queue entry for each character that causes a result.
// ----------------------------------------------------------------------------
module hmip_front #(
   parameter int ADDR_WIDTH      = 32,
   parameter int MAX_ADDR_DIGITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          ch,
   input  logic                last,
   input  logic                merge,
   output logic                q_push,
   output hmip_pkg::entry_type q_entry
);

   localparam int DCW = $clog2(MAX_ADDR_DIGITS + 1);

   hmip_pkg::mode_type      mode_ff, mode_in;
   logic [ADDR_WIDTH-1:0]   accum_ff, accum_in;
   logic [DCW-1:0]          dc_ff, dc_in;
   logic [ADDR_WIDTH-1:0]   next_ff, next_in;
   logic                    sec_ff, sec_in;
   logic [3:0]              high_ff, high_in;

   logic                    is_hex, is_space, fail, emit;
   logic [3:0]              hv;
   logic [ADDR_WIDTH-1:0]   shifted, fin_addr, prim_addr;
   logic                    merge_hit;
   logic [1:0]              prim_kind;
   logic [7:0]              prim_data;
   logic [63:0]             addr_wide;
   logic                    term_err;

   // Character classes
   always_comb begin
      is_hex = 1'b1;
      hv     = 4'd0;
      if (ch >= 8'h30 && ch <= 8'h39) begin
         hv = ch[3:0];
      end else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
         hv = 4'(ch[3:0] + 4'd9);
      end else begin
         is_hex = 1'b0;
      end
   end

   assign is_space = (ch == hmip_pkg::CHAR_SPACE) || (ch == hmip_pkg::CHAR_TAB) ||
                     (ch == hmip_pkg::CHAR_LF) || (ch == hmip_pkg::CHAR_VT) ||
                     (ch == hmip_pkg::CHAR_FF) || (ch == hmip_pkg::CHAR_CR);

   // Address completion: merged when it continues the open section
   assign shifted   = {accum_ff[ADDR_WIDTH-5:0], hv};
   assign fin_addr  = is_hex ? shifted : accum_ff;
   assign merge_hit = sec_ff && merge && (fin_addr == next_ff);

   // Next state and result selection
   always_comb begin
      mode_in   = mode_ff;
      accum_in  = accum_ff;
      dc_in     = dc_ff;
      next_in   = next_ff;
      sec_in    = sec_ff;
      high_in   = high_ff;
      fail      = 1'b0;
      emit      = 1'b0;
      prim_kind = hmip_pkg::KIND_BYTE;
      prim_addr = next_ff;
      prim_data = 8'd0;
      term_err  = 1'b0;
      if (accept) begin
         case (mode_ff)
            hmip_pkg::MODE_IDLE: begin
               if (is_space) begin
                  mode_in = hmip_pkg::MODE_IDLE;
               end else if (ch == hmip_pkg::CHAR_SLASH) begin
                  mode_in = hmip_pkg::MODE_SLASH;
               end else if (ch == hmip_pkg::CHAR_AT) begin
                  mode_in  = hmip_pkg::MODE_ADDR;
                  accum_in = '0;
                  dc_in    = '0;
               end else if (is_hex && sec_ff) begin
                  high_in = hv;
                  mode_in = hmip_pkg::MODE_NIBBLE;
               end else begin
                  fail = 1'b1;
               end
            end
            hmip_pkg::MODE_SLASH: begin
               if (ch == hmip_pkg::CHAR_SLASH) begin
                  mode_in = hmip_pkg::MODE_LINE;
               end else if (ch == hmip_pkg::CHAR_STAR) begin
                  mode_in = hmip_pkg::MODE_BLOCK;
               end else begin
                  fail = 1'b1;
               end
            end
            hmip_pkg::MODE_LINE: begin
               if (ch == hmip_pkg::CHAR_LF) mode_in = hmip_pkg::MODE_IDLE;
            end
            hmip_pkg::MODE_BLOCK: begin
               if (ch == hmip_pkg::CHAR_STAR) mode_in = hmip_pkg::MODE_STAR;
            end
            hmip_pkg::MODE_STAR: begin
               if (ch == hmip_pkg::CHAR_SLASH) begin
                  mode_in = hmip_pkg::MODE_IDLE;
               end else if (ch != hmip_pkg::CHAR_STAR) begin
                  mode_in = hmip_pkg::MODE_BLOCK;
               end
            end
            hmip_pkg::MODE_ADDR: begin
               if (is_hex && (dc_ff >= DCW'(MAX_ADDR_DIGITS))) begin
                  fail = 1'b1;
               end else if (!is_hex && (dc_ff == '0)) begin
                  fail = 1'b1;
               end else begin
                  if (is_hex) begin
                     accum_in = shifted;
                     dc_in    = dc_ff + DCW'(1);
                  end
                  // a non-digit ends the address and is swallowed
                  if (!is_hex || last) begin
                     mode_in = hmip_pkg::MODE_IDLE;
                     if (!merge_hit) begin
                        emit      = 1'b1;
                        prim_kind = hmip_pkg::KIND_SECTION;
                        prim_addr = fin_addr;
                        sec_in    = 1'b1;
                        next_in   = fin_addr;
                     end
                  end
               end
            end
            hmip_pkg::MODE_NIBBLE: begin
               if (is_hex) begin
                  emit      = 1'b1;
                  prim_kind = hmip_pkg::KIND_BYTE;
                  prim_addr = next_ff;
                  prim_data = {high_ff, hv};
                  next_in   = next_ff + ADDR_WIDTH'(1);
                  mode_in   = hmip_pkg::MODE_IDLE;
               end else begin
                  fail = 1'b1;
               end
            end
            hmip_pkg::MODE_DISCARD: begin
               mode_in = hmip_pkg::MODE_DISCARD;
            end
            default: begin
               mode_in = hmip_pkg::MODE_DISCARD;
            end
         endcase
         if (fail) mode_in = hmip_pkg::MODE_DISCARD;
         // last character closes the run and clears it
         if (last) begin
            term_err = !((mode_in == hmip_pkg::MODE_IDLE) ||
                         (mode_in == hmip_pkg::MODE_LINE));
            mode_in  = hmip_pkg::MODE_IDLE;
            accum_in = '0;
            dc_in    = '0;
            next_in  = '0;
            sec_in   = 1'b0;
            high_in  = 4'd0;
         end
      end
   end

   // Queue entry
   assign addr_wide = 64'(prim_addr);
   assign q_push    = accept && (emit || last);
   always_comb begin
      q_entry.has_prim  = emit;
      q_entry.prim_kind = prim_kind;
      q_entry.addr      = addr_wide[31:0];
      q_entry.data      = prim_data;
      q_entry.has_term  = last;
      q_entry.term_err  = term_err;
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= hmip_pkg::MODE_IDLE;
         accum_ff <= '0;
         dc_ff    <= '0;
         next_ff  <= '0;
         sec_ff   <= 1'b0;
         high_ff  <= 4'd0;
      end else begin
         mode_ff  <= mode_in;
         accum_ff <= accum_in;
         dc_ff    <= dc_in;
         next_ff  <= next_in;
         sec_ff   <= sec_in;
         high_ff  <= high_in;
      end
   end

endmodule

// File: rtl/hmip_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmip_queue
// Short entry queue between front and back, so each side stalls on its own.
// ----------------------------------------------------------------------------
module hmip_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  hmip_pkg::entry_type entry_in,
   output logic                full,
   input  logic                pop,
   output hmip_pkg::entry_type entry_out,
   output logic                empty
);

   localparam int PW = hmip_pkg::QUEUE_PTR_W;

   hmip_pkg::entry_type slot_ff [hmip_pkg::QUEUE_DEPTH];
   logic [PW-1:0]       wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]         cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign full      = (cnt_ff == (PW+1)'(hmip_pkg::QUEUE_DEPTH));
   assign empty     = (cnt_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign entry_out = slot_ff[rd_ff];

   // Pointer and count update
   always_comb begin
      wr_in  = do_push ? wr_ff + PW'(1) : wr_ff;
      rd_in  = do_pop  ? rd_ff + PW'(1) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) cnt_in = cnt_ff + (PW+1)'(1);
      else if (!do_push && do_pop) cnt_in = cnt_ff - (PW+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= entry_in;
   end

endmodule

// File: rtl/hmip_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmip_back
// Turns queue entries into result beats: a byte or section start first,
// then done or error, through one output register.
// ----------------------------------------------------------------------------
module hmip_back (
   input  logic                clock,
   input  logic                reset,
   input  hmip_pkg::entry_type head,
   input  logic                head_empty,
   output logic                head_pop,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [1:0]          rsp_kind,
   output logic [31:0]         rsp_address,
   output logic [7:0]          rsp_data,
   output logic                rsp_last_of_run
);

   logic        valid_ff, valid_in;
   logic        phase_ff, phase_in;   // primary beat of head already sent
   logic [1:0]  kind_ff, kind_in;
   logic [31:0] addr_ff, addr_in;
   logic [7:0]  data_ff, data_in;
   logic        lastr_ff, lastr_in;
   logic        load, take;

   assign load = !valid_ff || rsp_pop;
   assign take = load && !head_empty;

   // Beat selection
   always_comb begin
      valid_in = load ? !head_empty : valid_ff;
      phase_in = phase_ff;
      kind_in  = kind_ff;
      addr_in  = addr_ff;
      data_in  = data_ff;
      lastr_in = lastr_ff;
      head_pop = 1'b0;
      if (take) begin
         if (head.has_prim && !phase_ff) begin
            kind_in  = head.prim_kind;
            addr_in  = head.addr;
            data_in  = head.data;
            lastr_in = !head.has_term;
            if (head.has_term) phase_in = 1'b1;
            else head_pop = 1'b1;
         end else begin
            kind_in  = head.term_err ? hmip_pkg::KIND_ERROR : hmip_pkg::KIND_DONE;
            addr_in  = 32'd0;
            data_in  = 8'd0;
            lastr_in = 1'b1;
            phase_in = 1'b0;
            head_pop = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   // Output payload
   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      addr_ff  <= addr_in;
      data_ff  <= data_in;
      lastr_ff <= lastr_in;
   end

   assign rsp_empty       = !valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_address     = addr_ff;
   assign rsp_data        = data_ff;
   assign rsp_last_of_run = lastr_ff;

endmodule

// File: rtl/hex_memory_image_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_memory_image_parser
// Parses hex memory image text into byte writes and section starts.
// ----------------------------------------------------------------------------
// Usage:
//  - Input: push one character (req_ch, req_last) per cycle while req_full
//    is low. req_last marks the final character of an image.
//  - Results: while rsp_empty is low the oldest beat sits on rsp_kind,
//    rsp_address, rsp_data, rsp_last_of_run; rsp_pop takes it.
//  - csr_merge_adjacent is written with csr_valid; csr_ready is always high.
//    Write it only while the block is idle.
//  - A character is classified as it is accepted; its first result reaches
//    the ports through the queue and the output register. One character per cycle
//    is taken sustained while req_full is low; a character with two results
//    (section start or byte, then done) leaves through the single output
//    register as two beats.
//  - A four-entry queue between the parser and the output stage absorbs
//    stalls; when the receiver stops popping, the queue fills and req_full
//    rises.
//  - Reset empties the queue and output, returns the parser to idle and sets merging on.
// ----------------------------------------------------------------------------
module hex_memory_image_parser #(
   parameter int ADDR_WIDTH      = 32,
   parameter int MAX_ADDR_DIGITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_ch,
   input  logic        req_last,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_kind,
   output logic [31:0] rsp_address,
   output logic [7:0]  rsp_data,
   output logic        rsp_last_of_run,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_merge_adjacent
);

   logic                merge_ff, merge_in;
   logic                accept, q_push, q_full, q_pop, q_empty;
   hmip_pkg::entry_type q_wr, q_rd;
   logic                rsp_run_end, rsp_payload_zero;

   // Configuration register
   assign csr_ready = 1'b1;
   assign merge_in  = (csr_valid && csr_ready) ? csr_merge_adjacent : merge_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         merge_ff <= 1'b1;
      end else begin
         merge_ff <= merge_in;
      end
   end

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   hmip_front #(
      .ADDR_WIDTH      (ADDR_WIDTH),
      .MAX_ADDR_DIGITS (MAX_ADDR_DIGITS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .ch      (req_ch),
      .last    (req_last),
      .merge   (merge_ff),
      .q_push  (q_push),
      .q_entry (q_wr)
   );

   hmip_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .entry_in  (q_wr),
      .full      (q_full),
      .pop       (q_pop),
      .entry_out (q_rd),
      .empty     (q_empty)
   );

   hmip_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (q_rd),
      .head_empty      (q_empty),
      .head_pop        (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_kind        (rsp_kind),
      .rsp_address     (rsp_address),
      .rsp_data        (rsp_data),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // Checks
   assign rsp_run_end      = !rsp_empty && (rsp_kind == hmip_pkg::KIND_ERROR ||
                                            rsp_kind == hmip_pkg::KIND_DONE);
   assign rsp_payload_zero = (rsp_address == 32'd0) && (rsp_data == 8'd0);

   `include "hex_memory_image_parser_macros.svh"

   `HMIP_ASSERT_NOW(a_no_overflow, clock, reset, q_push, !q_full, "queue push while full")
   `HMIP_ASSERT_NOW(a_term_last, clock, reset, rsp_run_end, rsp_last_of_run, "end beat not last")
   `HMIP_ASSERT_NOW(a_term_zero, clock, reset, rsp_run_end, rsp_payload_zero, "end beat payload")
   `HMIP_ASSERT_NEXT(a_pop_empty, clock, reset, q_pop, !($past(q_empty)), "pop while empty")

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the hex memory image parser. Image text is pushed one
// character per beat: a short directed set first, then random image runs
// built from addresses, data bytes, comments, whitespace and some noise.
// A scoreboard predicts every result beat and compares it field by field
// as the beat is popped. The merge register is toggled between phases.
// ----------------------------------------------------------------------------
package hmip_tb_pkg;

   localparam int MAX_DIGITS = 16;

   localparam logic [7:0] CH_ZERO    = "0";
   localparam logic [7:0] CH_NINE    = "9";
   localparam logic [7:0] CH_LOWER_A = "a";
   localparam logic [7:0] CH_LOWER_F = "f";
   localparam logic [7:0] CH_UPPER_A = "A";
   localparam logic [7:0] CH_UPPER_F = "F";

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] address;
      logic [7:0]  data;
      logic        run_end;
   } beat_type;

   // Parser model and store of expected result beats
   class image_scoreboard;
      bit                 merge_on = 1'b1;
      hmip_pkg::mode_type mode = hmip_pkg::MODE_IDLE;
      logic [31:0]        addr_acc = '0;
      logic [31:0]        next_addr = '0;
      int                 digit_cnt = 0;
      bit                 section_live = 1'b0;
      logic [3:0]         hi_nib = '0;
      beat_type           pending_beats[$];
      int                 n_fail, n_byte, n_section, n_error, n_done;

      function void clear_run();
         mode         = hmip_pkg::MODE_IDLE;
         addr_acc     = '0;
         digit_cnt    = 0;
         next_addr    = '0;
         section_live = 1'b0;
         hi_nib       = '0;
      endfunction

      // -1 for a character that is not a hex digit
      function int nibble_of(logic [7:0] c);
         if (c >= CH_ZERO && c <= CH_NINE) return int'(c) - int'(CH_ZERO);
         if (c >= CH_LOWER_A && c <= CH_LOWER_F) return int'(c) - int'(CH_LOWER_A) + 10;
         if (c >= CH_UPPER_A && c <= CH_UPPER_F) return int'(c) - int'(CH_UPPER_A) + 10;
         return -1;
      endfunction

      function bit is_blank(logic [7:0] c);
         return c == hmip_pkg::CHAR_SPACE || c == hmip_pkg::CHAR_TAB ||
                c == hmip_pkg::CHAR_LF || c == hmip_pkg::CHAR_VT ||
                c == hmip_pkg::CHAR_FF || c == hmip_pkg::CHAR_CR;
      endfunction

      function void add_beat(logic [1:0] k, logic [31:0] a, logic [7:0] d);
         beat_type b;
         b.kind    = k;
         b.address = a;
         b.data    = d;
         b.run_end = 1'b0;
         pending_beats.push_back(b);
      endfunction

      // A contiguous address under merging opens no new section
      function void close_address();
         if (section_live && merge_on && addr_acc == next_addr) return;
         section_live = 1'b1;
         next_addr    = addr_acc;
         add_beat(hmip_pkg::KIND_SECTION, addr_acc, 8'h00);
      endfunction

      // Accepted character: work out the beats it causes
      function void note_char(logic [7:0] c, logic is_last);
         int       v;
         bit       fail;
         int       n_before;
         beat_type tail_beat;
         v        = nibble_of(c);
         fail     = 1'b0;
         n_before = pending_beats.size();
         case (mode)
            hmip_pkg::MODE_IDLE: begin
               if (c == hmip_pkg::CHAR_SLASH) begin
                  mode = hmip_pkg::MODE_SLASH;
               end else if (c == hmip_pkg::CHAR_AT) begin
                  mode      = hmip_pkg::MODE_ADDR;
                  addr_acc  = '0;
                  digit_cnt = 0;
               end else if (v >= 0 && section_live) begin
                  hi_nib = v[3:0];
                  mode   = hmip_pkg::MODE_NIBBLE;
               end else if (!is_blank(c)) begin
                  fail = 1'b1;
               end
            end
            hmip_pkg::MODE_SLASH: begin
               if (c == hmip_pkg::CHAR_SLASH) mode = hmip_pkg::MODE_LINE;
               else if (c == hmip_pkg::CHAR_STAR) mode = hmip_pkg::MODE_BLOCK;
               else fail = 1'b1;
            end
            hmip_pkg::MODE_LINE: begin
               if (c == hmip_pkg::CHAR_LF) mode = hmip_pkg::MODE_IDLE;
            end
            hmip_pkg::MODE_BLOCK: begin
               if (c == hmip_pkg::CHAR_STAR) mode = hmip_pkg::MODE_STAR;
            end
            hmip_pkg::MODE_STAR: begin
               if (c == hmip_pkg::CHAR_SLASH) mode = hmip_pkg::MODE_IDLE;
               else if (c != hmip_pkg::CHAR_STAR) mode = hmip_pkg::MODE_BLOCK;
            end
            hmip_pkg::MODE_ADDR: begin
               if (v >= 0) begin
                  if (digit_cnt >= MAX_DIGITS) begin
                     fail = 1'b1;
                  end else begin
                     addr_acc  = {addr_acc[27:0], v[3:0]};
                     digit_cnt = digit_cnt + 1;
                     if (is_last) begin
                        close_address();
                        mode = hmip_pkg::MODE_IDLE;
                     end
                  end
               end else if (digit_cnt == 0) begin
                  fail = 1'b1;
               end else begin
                  // terminator is swallowed
                  close_address();
                  mode = hmip_pkg::MODE_IDLE;
               end
            end
            hmip_pkg::MODE_NIBBLE: begin
               if (v >= 0) begin
                  add_beat(hmip_pkg::KIND_BYTE, next_addr, {hi_nib, v[3:0]});
                  next_addr = next_addr + 32'd1;
                  mode      = hmip_pkg::MODE_IDLE;
               end else begin
                  fail = 1'b1;
               end
            end
            default: ;  // discarding until the last character
         endcase
         if (fail) mode = hmip_pkg::MODE_DISCARD;
         if (is_last) begin
            if (mode == hmip_pkg::MODE_IDLE || mode == hmip_pkg::MODE_LINE)
               add_beat(hmip_pkg::KIND_DONE, '0, '0);
            else
               add_beat(hmip_pkg::KIND_ERROR, '0, '0);
            clear_run();
         end
         if (pending_beats.size() > n_before) begin
            tail_beat         = pending_beats.pop_back();
            tail_beat.run_end = 1'b1;
            pending_beats.push_back(tail_beat);
         end
      endfunction

      // Popped beat against the oldest expectation
      function void check_beat(beat_type got);
         beat_type want;
         if (pending_beats.size() == 0) begin
            $error("unexpected result beat: kind %0d address %h data %h",
                   got.kind, got.address, got.data);
            n_fail++;
            return;
         end
         want = pending_beats.pop_front();
         if (got.kind !== want.kind) begin
            $error("rsp_kind mismatch: expected %0d, actual %0d", want.kind, got.kind);
            n_fail++;
         end
         if (got.address !== want.address) begin
            $error("rsp_address mismatch: expected %h, actual %h", want.address, got.address);
            n_fail++;
         end
         if (got.data !== want.data) begin
            $error("rsp_data mismatch: expected %h, actual %h", want.data, got.data);
            n_fail++;
         end
         if (got.run_end !== want.run_end) begin
            $error("rsp_last_of_run mismatch: expected %0d, actual %0d",
                   want.run_end, got.run_end);
            n_fail++;
         end
         case (want.kind)
            hmip_pkg::KIND_BYTE:    n_byte++;
            hmip_pkg::KIND_SECTION: n_section++;
            hmip_pkg::KIND_ERROR:   n_error++;
            default:                n_done++;
         endcase
      endfunction
   endclass

endpackage

module tb;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int ITEMS_TOTAL   = 1700;
   localparam int PHASES        = 4;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 300;
   localparam int TAIL_CYCLES   = 20;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_ch = '0;
   logic        req_last = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [1:0]  rsp_kind;
   logic [31:0] rsp_address;
   logic [7:0]  rsp_data;
   logic        rsp_last_of_run;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_merge_adjacent = 1'b1;

   hmip_tb_pkg::image_scoreboard sb;
   int          cycle_count = 0;
   int          chars_sent = 0;
   int          runs_sent = 0;
   bit          steady = 1'b0;
   bit          hold_request = 1'b0;
   logic [31:0] gen_next = '0;   // byte address the generated text has reached
   logic [7:0]  run_text[$];

   hex_memory_image_parser u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_ch             (req_ch),
      .req_last           (req_last),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_kind           (rsp_kind),
      .rsp_address        (rsp_address),
      .rsp_data           (rsp_data),
      .rsp_last_of_run    (rsp_last_of_run),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_merge_adjacent (csr_merge_adjacent)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Result side: random pops, one long hold-off on request
   initial begin
      int                    hold_left;
      bit                    held;
      hmip_tb_pkg::beat_type got;
      hold_left = 0;
      held      = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_pop && !rsp_empty) begin
            got.kind    = rsp_kind;
            got.address = rsp_address;
            got.data    = rsp_data;
            got.run_end = rsp_last_of_run;
            sb.check_beat(got);
         end
         if (hold_request && !held) begin
            held      = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= steady || ($urandom_range(99) >= 25);
         end
      end
   end

   // One character beat, with random gaps ahead of it
   task automatic send_char(logic [7:0] c, logic is_last);
      while (!steady && $urandom_range(99) < 25) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_ch   <= c;
      req_last <= is_last;
      @(posedge clock);
      while (req_full) @(posedge clock);
      sb.note_char(c, is_last);
      chars_sent++;
   endtask

   task automatic send_run();
      foreach (run_text[i]) send_char(run_text[i], i == run_text.size() - 1);
      run_text.delete();
      runs_sent++;
   endtask

   task automatic wait_for_drain();
      req_push <= 1'b0;
      while (sb.pending_beats.size() != 0) @(posedge clock);
   endtask

   // Register write while idle; a character with no result may still be in flight
   task automatic write_merge(logic m);
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid          <= 1'b1;
      csr_merge_adjacent <= m;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid   <= 1'b0;
      sb.merge_on = m;
   endtask

   // ---- text generation ----

   function automatic logic [7:0] hex_char(logic [3:0] n);
      if (n < 4'd10) return hmip_tb_pkg::CH_ZERO + 8'(n);
      return ($urandom_range(1) ? hmip_tb_pkg::CH_UPPER_A : hmip_tb_pkg::CH_LOWER_A) +
             8'(n - 4'd10);
   endfunction

   function automatic logic [7:0] blank_char();
      case ($urandom_range(5))
         0:       return hmip_pkg::CHAR_TAB;
         1:       return hmip_pkg::CHAR_LF;
         2:       return hmip_pkg::CHAR_VT;
         3:       return hmip_pkg::CHAR_FF;
         4:       return hmip_pkg::CHAR_CR;
         default: return hmip_pkg::CHAR_SPACE;
      endcase
   endfunction

   function automatic void push_str(string s);
      for (int i = 0; i < s.len(); i++) run_text.push_back(s[i]);
   endfunction

   // Half the time continues the current section; otherwise random or near the wrap
   function automatic void add_address(bit at_end);
      int          nd;
      int          pick;
      logic [63:0] val;
      logic [31:0] acc;
      logic [3:0]  d;
      pick = $urandom_range(9);
      if (pick < 5) begin
         val = {32'h0, gen_next};
         nd  = $urandom_range(8, hmip_tb_pkg::MAX_DIGITS);
      end else if (pick < 8) begin
         val = {$urandom, $urandom};
         nd  = $urandom_range(1, hmip_tb_pkg::MAX_DIGITS);
      end else begin
         val = {32'h0, 32'hFFFF_FFF8 + 32'($urandom_range(7))};
         nd  = 8;
      end
      if ($urandom_range(39) == 0) nd = hmip_tb_pkg::MAX_DIGITS + 1;
      run_text.push_back(hmip_pkg::CHAR_AT);
      acc = '0;
      for (int i = nd - 1; i >= 0; i--) begin
         d   = (i < hmip_tb_pkg::MAX_DIGITS) ? val[4*i +: 4] : 4'($urandom_range(15));
         acc = {acc[27:0], d};
         run_text.push_back(hex_char(d));
      end
      gen_next = acc;
      if (!at_end)
         run_text.push_back($urandom_range(3) == 0 ? 8'($urandom_range(255)) : blank_char());
   endfunction

   function automatic void add_data();
      int         n;
      logic [7:0] b;
      n = $urandom_range(1, 8);
      repeat (n) begin
         b = 8'($urandom_range(255));
         run_text.push_back(hex_char(b[7:4]));
         run_text.push_back(hex_char(b[3:0]));
         if ($urandom_range(1)) run_text.push_back(blank_char());
      end
      gen_next = gen_next + 32'(n);
   endfunction

   function automatic void add_line_comment();
      logic [7:0] c;
      push_str("//");
      repeat ($urandom_range(0, 6)) begin
         c = 8'($urandom_range(255));
         run_text.push_back(c == hmip_pkg::CHAR_LF ? hmip_pkg::CHAR_SPACE : c);
      end
      run_text.push_back(hmip_pkg::CHAR_LF);
   endfunction

   // Body may hold star runs; closed by one or more stars and a slash
   function automatic void add_block_comment();
      logic [7:0] c;
      push_str("/*");
      repeat ($urandom_range(0, 5)) begin
         if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3)) run_text.push_back(hmip_pkg::CHAR_STAR);
         c = 8'($urandom_range(255));
         run_text.push_back(c == hmip_pkg::CHAR_SLASH ? hmip_pkg::CHAR_SPACE : c);
      end
      repeat ($urandom_range(1, 3)) run_text.push_back(hmip_pkg::CHAR_STAR);
      run_text.push_back(hmip_pkg::CHAR_SLASH);
   endfunction

   function automatic void add_noise();
      logic [7:0] c;
      case ($urandom_range(4))
         0: run_text.push_back(8'($urandom_range(255)));
         1: begin
            // odd digit
            run_text.push_back(hex_char(4'($urandom_range(15))));
            run_text.push_back(blank_char());
         end
         2: begin
            // lone slash
            c = 8'($urandom_range(255));
            run_text.push_back(hmip_pkg::CHAR_SLASH);
            run_text.push_back((c == hmip_pkg::CHAR_SLASH || c == hmip_pkg::CHAR_STAR) ?
                               hmip_pkg::CHAR_SPACE : c);
         end
         3: begin
            // empty address
            run_text.push_back(hmip_pkg::CHAR_AT);
            if ($urandom_range(1)) run_text.push_back(blank_char());
            else push_str("_");
         end
         default: push_str("_");
      endcase
   endfunction

   // One image run: mostly well formed, with the odd broken piece or ending
   function automatic void build_run();
      int pick;
      logic [7:0] c;
      if ($urandom_range(19) != 0) add_address(1'b0);
      repeat ($urandom_range(1, 8)) begin
         pick = $urandom_range(99);
         if (pick < 44) add_data();
         else if (pick < 58) add_address(1'b0);
         else if (pick < 80) repeat ($urandom_range(1, 3)) run_text.push_back(blank_char());
         else if (pick < 88) add_line_comment();
         else if (pick < 97) add_block_comment();
         else add_noise();
      end
      case ($urandom_range(19))
         0: add_address(1'b1);
         1: begin
            // ends inside a block comment
            push_str("/*");
            run_text.push_back(8'($urandom_range(255)));
         end
         2: begin
            // ends inside a line comment
            c = 8'($urandom_range(255));
            push_str("//");
            run_text.push_back(c == hmip_pkg::CHAR_LF ? hmip_pkg::CHAR_SPACE : c);
         end
         3: run_text.push_back(hmip_pkg::CHAR_AT);
         4: run_text.push_back(hmip_pkg::CHAR_SLASH);
         5: run_text.push_back(hex_char(4'($urandom_range(15))));
         default: ;
      endcase
   endfunction

   // ---- main sequence ----
   initial begin
      bit drained_once;
      drained_once = 1'b0;
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int ph = 0; ph < PHASES; ph++) begin
         write_merge(ph % 2 == 0);
         if (ph == 0) begin
            // section, byte extremes, clean end
            push_str("@0 00fF");
            send_run();
            // star run closes the comment, then an underscore
            push_str("/*x**/_");
            send_run();
            // lone slash at the end
            run_text.push_back(hmip_pkg::CHAR_SLASH);
            send_run();
            // address running into the last character
            push_str("@7");
            send_run();
            // data before any address
            push_str("5");
            send_run();
            // empty address at the end
            run_text.push_back(hmip_pkg::CHAR_AT);
            send_run();
            // open comment at the end, character extremes inside
            push_str("/*");
            run_text.push_back(8'h00);
            run_text.push_back(8'hFF);
            send_run();
         end
         while (chars_sent < ITEMS_TOTAL * (ph + 1) / PHASES) begin
            steady = chars_sent >= 800 && chars_sent < 1100;
            if (chars_sent >= 500) hold_request = 1'b1;
            if (!drained_once && chars_sent >= 1200) begin
               drained_once = 1'b1;
               wait_for_drain();
            end
            build_run();
            send_run();
         end
      end

      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Ran %0d characters in %0d image runs over %0d merge settings.",
               chars_sent, runs_sent, PHASES);
      $display("Beats checked: %0d bytes, %0d section starts, %0d errors, %0d clean ends.",
               sb.n_byte, sb.n_section, sb.n_error, sb.n_done);
      if (sb.n_fail == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/hmip_pkg.sv
rtl/hmip_front.sv
rtl/hmip_queue.sv
rtl/hmip_back.sv
rtl/hex_memory_image_parser.sv
dv/tb.sv
